/* rtl/firer_pkg.sv */
// Shared constants and types for the edge-replicating FIR filter.
`default_nettype none
package firer_pkg;

    // Coefficient format: signed Q2.14
    localparam int COEF_BITS  = 16;
    localparam int FRAC_BITS  = 14;
    localparam int ROUND_BIAS = 1 << (FRAC_BITS - 1);

    // Configuration port
    localparam int APB_DATA_BITS = 32;
    localparam int HW_BITS       = 2;

    // Register indexes (byte address is four times the index)
    localparam int REG_HALF_WIDTH = 0;
    localparam int REG_COEF_BASE  = 1;

    // Reset values of the configuration
    localparam logic [HW_BITS-1:0]          HW_RESET          = 2'd1;
    localparam logic signed [COEF_BITS-1:0] COEF_RESET_SIDE   = 16'sd4096;
    localparam logic signed [COEF_BITS-1:0] COEF_RESET_CENTRE = 16'sd8192;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage
`default_nettype wire

/* rtl/firer_cfg.sv */
// Configuration register file: half width and tap weights behind an APB-style port.
`default_nettype none
module firer_cfg #(
    parameter int MAX_HALF  = 3,
    parameter int ADDR_BITS = 5
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     psel,
    input  wire logic                                     penable,
    input  wire logic                                     pwrite,
    input  wire logic [ADDR_BITS-1:0]                     paddr,
    input  wire logic [firer_pkg::APB_DATA_BITS-1:0]      pwdata,
    output logic      [firer_pkg::APB_DATA_BITS-1:0]      prdata,
    output logic                                          pready,
    output logic      [firer_pkg::HW_BITS-1:0]            half_width,
    output logic [2*MAX_HALF:0][firer_pkg::COEF_BITS-1:0] coefs
);

    localparam int TAPS = 2 * MAX_HALF + 1;
    localparam int IW   = $clog2(TAPS);
    localparam int XW   = ADDR_BITS - 2;

    logic [firer_pkg::HW_BITS-1:0]                half_width_reg;
    logic [TAPS-1:0][firer_pkg::COEF_BITS-1:0]    coef_reg;
    logic [XW-1:0]                                idx;
    logic                                         is_hw;
    logic                                         is_coef;
    logic [IW-1:0]                                coef_idx;
    logic                                         wr_en;

    // Address decode
    always_comb
    begin
        idx      = paddr[ADDR_BITS-1:2];
        is_hw    = (int'(idx) == firer_pkg::REG_HALF_WIDTH);
        is_coef  = (int'(idx) >= firer_pkg::REG_COEF_BASE)
                   && (int'(idx) < firer_pkg::REG_COEF_BASE + TAPS);
        coef_idx = IW'(int'(idx) - firer_pkg::REG_COEF_BASE);
        wr_en    = psel && penable && pwrite;
        pready   = 1'b1;
    end

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg <= firer_pkg::HW_RESET;
            for (int j = 0; j < TAPS; j++)
            begin
                if (j == MAX_HALF)
                    coef_reg[j] <= firer_pkg::COEF_RESET_CENTRE;
                else if (j == MAX_HALF - 1 || j == MAX_HALF + 1)
                    coef_reg[j] <= firer_pkg::COEF_RESET_SIDE;
                else
                    coef_reg[j] <= '0;
            end
        end
        else if (wr_en)
        begin
            if (is_hw)
                half_width_reg <= pwdata[firer_pkg::HW_BITS-1:0];
            else if (is_coef)
                coef_reg[coef_idx] <= pwdata[firer_pkg::COEF_BITS-1:0];
        end
    end

    // Read back, weights sign-extended
    always_comb
    begin
        prdata = '0;
        if (is_hw)
            prdata = firer_pkg::APB_DATA_BITS'(half_width_reg);
        else if (is_coef)
            prdata = {{(firer_pkg::APB_DATA_BITS - firer_pkg::COEF_BITS)
                        {coef_reg[coef_idx][firer_pkg::COEF_BITS-1]}},
                      coef_reg[coef_idx]};
    end

    assign half_width = half_width_reg;
    assign coefs      = coef_reg;

endmodule
`default_nettype wire

/* rtl/firer_front.sv */
// Front end: sample window, edge replication, flush sequencing and tap alignment.
`default_nettype none
module firer_front #(
    parameter int MAX_HALF    = 3,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic [firer_pkg::HW_BITS-1:0]         half_width,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [SAMPLE_BITS-1:0]                in_sample,
    input  wire logic                                  in_final,
    input  wire firer_pkg::q_status_t                  q_stat,
    output logic                                       push,
    output logic [2*MAX_HALF:0][SAMPLE_BITS-1:0]       push_taps,
    output logic                                       push_final
);

    localparam int TAPS = 2 * MAX_HALF + 1;
    localparam int KW   = $clog2(MAX_HALF + 1);
    localparam int IW   = $clog2(TAPS);

    logic [TAPS-1:0][SAMPLE_BITS-1:0] win_reg, win_next;
    logic [KW-1:0]                    fill_reg, fill_next;
    logic                             inseq_reg, inseq_next;
    logic [KW-1:0]                    left_reg, left_next;

    logic [KW-1:0]                    k;
    logic [KW-1:0]                    c;
    logic [KW-1:0]                    pre;
    logic [KW-1:0]                    total_m1;
    logic                             flushing;
    logic                             accept;
    logic                             step;
    logic [TAPS-1:0][SAMPLE_BITS-1:0] w_in;
    logic [TAPS-1:0][SAMPLE_BITS-1:0] w_pre;
    logic [TAPS-1:0][SAMPLE_BITS-1:0] w_fl;
    logic [TAPS-1:0][SAMPLE_BITS-1:0] sel_w;

    // Window candidates and flush bookkeeping
    always_comb
    begin
        int idx;
        k        = (int'(half_width) > MAX_HALF) ? KW'(MAX_HALF) : KW'(half_width);
        flushing = (left_reg != '0);
        in_ready = !flushing && !q_stat.full;
        accept   = in_valid && in_ready;
        step     = flushing && !q_stat.full;
        c        = inseq_reg ? fill_reg : '0;
        pre      = (c >= k) ? '0 : KW'(k - c);
        total_m1 = (c >= k) ? k : c;

        // new sample shifted in, or the whole window filled on a first sample
        w_in[0] = in_sample;
        w_fl[0] = win_reg[0];
        for (int j = 1; j < TAPS; j++)
        begin
            w_in[j] = inseq_reg ? win_reg[j-1] : in_sample;
            w_fl[j] = win_reg[j-1];
        end

        // right-edge padding: the final sample shifted in again pre times
        for (int j = 0; j < TAPS; j++)
        begin
            idx = j - int'(pre);
            if (idx < 0)
                w_pre[j] = in_sample;
            else
                w_pre[j] = w_in[IW'(idx)];
        end
    end

    // Next state and queue push
    always_comb
    begin
        win_next   = win_reg;
        fill_next  = fill_reg;
        inseq_next = inseq_reg;
        left_next  = left_reg;
        push       = 1'b0;
        push_final = 1'b0;
        sel_w      = w_in;
        if (step)
        begin
            win_next   = w_fl;
            sel_w      = w_fl;
            push       = 1'b1;
            push_final = (left_reg == KW'(1));
            left_next  = KW'(left_reg - KW'(1));
        end
        else if (accept)
        begin
            inseq_next = 1'b1;
            if (!in_final)
            begin
                win_next = w_in;
                sel_w    = w_in;
                if (c >= k)
                begin
                    push      = 1'b1;
                    fill_next = c;
                end
                else
                    fill_next = KW'(c + KW'(1));
            end
            else
            begin
                win_next   = w_pre;
                sel_w      = w_pre;
                push       = 1'b1;
                push_final = (total_m1 == '0);
                left_next  = total_m1;
                fill_next  = '0;
                inseq_next = 1'b0;
            end
        end
    end

    // Align the window to the weight slots; slots outside the width read zero
    always_comb
    begin
        int idx;
        for (int j = 0; j < TAPS; j++)
        begin
            idx = int'(k) + MAX_HALF - j;
            if (idx >= 0 && idx <= 2 * int'(k))
                push_taps[j] = sel_w[IW'(idx)];
            else
                push_taps[j] = '0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            inseq_reg <= 1'b0;
            left_reg  <= '0;
        end
        else
        begin
            fill_reg  <= fill_next;
            inseq_reg <= inseq_next;
            left_reg  <= left_next;
        end
    end

    // Sample window
    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

`ifndef ASSERT_OFF
    // never write into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !q_stat.full)
        else $error("front pushed into a full queue");
    // a final sample closes the sequence
    assert property (@(posedge clk) disable iff (!rst_n) (accept && in_final) |=> !inseq_reg)
        else $error("sequence still open after final sample");
    // outside a sequence the fill count is clear
    assert property (@(posedge clk) disable iff (!rst_n) !inseq_reg |-> (fill_reg == '0))
        else $error("fill count set outside a sequence");
`endif

endmodule
`default_nettype wire

/* rtl/firer_queue.sv */
// Short FIFO carrying aligned tap sets from the front to the back.
`default_nettype none
module firer_queue #(
    parameter int WIDTH = 113
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rd_data,
    output firer_pkg::q_status_t  status
);

    localparam int PW = $clog2(firer_pkg::QUEUE_DEPTH);

    logic [WIDTH-1:0] mem_reg [firer_pkg::QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW:0]      count_reg;

    // Status flags
    always_comb
    begin
        status.full  = (int'(count_reg) == firer_pkg::QUEUE_DEPTH);
        status.empty = (count_reg == '0);
        rd_data      = mem_reg[rd_ptr_reg];
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= PW'(wr_ptr_reg + PW'(1));
            if (pop)
                rd_ptr_reg <= PW'(rd_ptr_reg + PW'(1));
            if (push && !pop)
                count_reg <= (PW+1)'(count_reg + (PW+1)'(1));
            else if (pop && !push)
                count_reg <= (PW+1)'(count_reg - (PW+1)'(1));
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule
`default_nettype wire

/* rtl/firer_back.sv */
// Back end: multiply stage, registered adder tree, rounding, saturation and output register.
`default_nettype none
module firer_back #(
    parameter int MAX_HALF    = 3,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire logic [2*MAX_HALF:0][firer_pkg::COEF_BITS-1:0] coefs,
    input  wire firer_pkg::q_status_t                       q_stat,
    input  wire logic [2*MAX_HALF:0][SAMPLE_BITS-1:0]       head_taps,
    input  wire logic                                       head_final,
    output logic                                            pop,
    output logic                                            out_valid,
    input  wire logic                                       out_ready,
    output logic      [SAMPLE_BITS-1:0]                     out_data,
    output logic                                            out_last
);

    localparam int TAPS      = 2 * MAX_HALF + 1;
    localparam int LEVELS    = $clog2(TAPS);
    localparam int PROD_BITS = firer_pkg::COEF_BITS + SAMPLE_BITS;
    localparam int ACC_BITS  = PROD_BITS + LEVELS + 1;
    localparam logic signed [ACC_BITS-1:0] SAT_HI =
        (ACC_BITS'(1) << (SAMPLE_BITS - 1)) - ACC_BITS'(1);
    localparam logic signed [ACC_BITS-1:0] SAT_LO = ~SAT_HI;
    localparam logic signed [ACC_BITS-1:0] BIAS   = ACC_BITS'(firer_pkg::ROUND_BIAS);

    logic signed [PROD_BITS-1:0] prod [TAPS];
    logic signed [ACC_BITS-1:0]  tree_reg  [LEVELS+1][TAPS];
    logic signed [ACC_BITS-1:0]  tree_next [LEVELS+1][TAPS];
    logic [LEVELS:0]             v_reg;
    logic [LEVELS:0]             last_reg;
    logic                        out_valid_reg;
    logic [SAMPLE_BITS-1:0]      out_data_reg;
    logic                        out_last_reg;
    logic                        en;
    logic signed [ACC_BITS-1:0]  rnd;
    logic signed [ACC_BITS-1:0]  shifted;
    logic [SAMPLE_BITS-1:0]      sat;

    // Pipeline moves while the output register is free or being drained
    always_comb
    begin
        en  = !out_valid_reg || out_ready;
        pop = en && !q_stat.empty;
    end

    // Products and pairwise tree sums
    always_comb
    begin
        for (int i = 0; i < TAPS; i++)
        begin
            prod[i]         = $signed(coefs[i]) * $signed(head_taps[i]);
            tree_next[0][i] = ACC_BITS'(prod[i]);
        end
        for (int l = 1; l <= LEVELS; l++)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                tree_next[l][i] = '0;
                if (2 * i < TAPS)
                    tree_next[l][i] = tree_reg[l-1][2*i];
                if (2 * i + 1 < TAPS)
                    tree_next[l][i] = tree_next[l][i] + tree_reg[l-1][2*i+1];
            end
        end
    end

    // Round to nearest (ties upward) and saturate
    always_comb
    begin
        rnd     = tree_reg[LEVELS][0] + BIAS;
        shifted = rnd >>> firer_pkg::FRAC_BITS;
        if (shifted > SAT_HI)
            sat = SAT_HI[SAMPLE_BITS-1:0];
        else if (shifted < SAT_LO)
            sat = SAT_LO[SAMPLE_BITS-1:0];
        else
            sat = shifted[SAMPLE_BITS-1:0];
    end

    // Stage valid flags and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg         <= {v_reg[LEVELS-1:0], pop};
            out_valid_reg <= v_reg[LEVELS];
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tree_reg     <= tree_next;
            last_reg     <= {last_reg[LEVELS-1:0], head_final};
            out_data_reg <= sat;
            out_last_reg <= last_reg[LEVELS];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

endmodule
`default_nettype wire

/* rtl/fir_filter_edge_replicate.sv */
// Top level of the edge-replicating centred FIR filter.
//
//  channel    | direction | handshake              | payload
//  -----------+-----------+------------------------+--------------------------------------
//  s_axis     | in        | tvalid / tready        | tdata: sample; tlast: final_sample
//  m_axis     | out       | tvalid / tready        | tdata: filtered; tlast: final_result
//  apb        | in        | psel / penable / pready| half_width at 0x00, coef_j at 4*(j+1)
//
// One sample per cycle is taken while the front queue has room and no flush is in
// progress. A final sample whose sequence still owes outputs (at most k) holds the
// input while the front shifts in replicated samples (k = clamped half width).
// A request passes through the queue, multiply, adder tree levels, round and saturate
// before it leaves. Reset is asynchronous and needs no clearing pass. Stalls on
// m_axis freeze the back; the four-entry queue lets the front keep accepting until
// it fills.
`default_nettype none
module fir_filter_edge_replicate #(
    parameter int MAX_HALF    = 3,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // stream in
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,  // [SB-1:0] sample
    input  wire logic                                 s_axis_tlast,
    // stream out
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    output logic      [((SAMPLE_BITS+7)/8)*8-1:0]     m_axis_tdata,  // [SB-1:0] filtered
    output logic                                      m_axis_tlast,
    // configuration
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [$clog2(8*(MAX_HALF+1))-1:0]    paddr,
    input  wire logic [firer_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic      [firer_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                      pready
);

    localparam int TAPS       = 2 * MAX_HALF + 1;
    localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int ADDR_BITS  = $clog2(8 * (MAX_HALF + 1));
    localparam int Q_WIDTH    = TAPS * SAMPLE_BITS + 1;

    logic [firer_pkg::HW_BITS-1:0]               half_width;
    logic [TAPS-1:0][firer_pkg::COEF_BITS-1:0]   coefs;
    firer_pkg::q_status_t                        q_stat;
    logic                                        push;
    logic [TAPS-1:0][SAMPLE_BITS-1:0]            push_taps;
    logic                                        push_final;
    logic                                        pop;
    logic [Q_WIDTH-1:0]                          q_rd;
    logic [TAPS-1:0][SAMPLE_BITS-1:0]            head_taps;
    logic                                        head_final;
    logic [SAMPLE_BITS-1:0]                      filtered;

    // Configuration registers
    firer_cfg #(
        .MAX_HALF  (MAX_HALF),
        .ADDR_BITS (ADDR_BITS)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .half_width (half_width),
        .coefs      (coefs)
    );

    // Front: window and flush control
    firer_front #(
        .MAX_HALF    (MAX_HALF),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .half_width (half_width),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_sample  (s_axis_tdata[SAMPLE_BITS-1:0]),
        .in_final   (s_axis_tlast),
        .q_stat     (q_stat),
        .push       (push),
        .push_taps  (push_taps),
        .push_final (push_final)
    );

    // Queue between front and back
    firer_queue #(
        .WIDTH (Q_WIDTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data ({push_final, push_taps}),
        .pop     (pop),
        .rd_data (q_rd),
        .status  (q_stat)
    );

    assign head_taps  = q_rd[Q_WIDTH-2:0];
    assign head_final = q_rd[Q_WIDTH-1];

    // Back: arithmetic pipeline and output register
    firer_back #(
        .MAX_HALF    (MAX_HALF),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .coefs      (coefs),
        .q_stat     (q_stat),
        .head_taps  (head_taps),
        .head_final (head_final),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (filtered),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = TDATA_BITS'(filtered);

endmodule
`default_nettype wire
